### hw/rtl/smta_pkg.sv
package smta_pkg;

  // configuration port geometry
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  // register map
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 2'd0;

  // window size register
  localparam int WSIZE_W = 7;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd3;

  // alert counter
  localparam int COUNT_W = 32;

  // per-cycle control broadcast to every cell of the sorted row
  typedef struct packed {
    logic upd;   // a word is accepted this cycle
    logic full;  // the window was full before this word
  } smta_ctl_t;

endpackage

### hw/rtl/smta_cell.sv
module smta_cell import smta_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int AGE_W       = 6,
  parameter int WCNT_W      = 7,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  smta_ctl_t              ctl,
  input  logic [SAMPLE_BITS-1:0] amount,
  input  logic [SAMPLE_BITS-1:0] rem_val,
  input  logic [WCNT_W-1:0]      fill,
  input  logic [AGE_W-1:0]       wm1,
  input  logic [AGE_W-1:0]       m_cnt,
  input  logic [AGE_W-1:0]       lo_idx,
  input  logic [AGE_W-1:0]       hi_idx,
  // from the right-hand neighbour
  input  logic [SAMPLE_BITS-1:0] right_val,
  input  logic [AGE_W-1:0]       right_age,
  input  logic                   right_s,
  // from the left-hand neighbour
  input  logic [SAMPLE_BITS-1:0] left_u,
  input  logic [AGE_W-1:0]       left_u_age,
  input  logic                   left_g,
  // to the neighbours
  output logic [SAMPLE_BITS-1:0] val,
  output logic [AGE_W-1:0]       age,
  output logic                   s,
  output logic [SAMPLE_BITS-1:0] u,
  output logic [AGE_W-1:0]       u_age,
  output logic                   g,
  // masked values for the broadcast or-trees
  output logic [SAMPLE_BITS-1:0] rem_part,
  output logic [SAMPLE_BITS-1:0] lo_part,
  output logic [SAMPLE_BITS-1:0] hi_part
);

  logic [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic [AGE_W-1:0]       age_r, age_nxt;
  logic                   occ;
  logic                   u_ok;

  assign val = val_r;
  assign age = age_r;

  // occupancy and the oldest sample
  assign occ      = (WCNT_W'(IDX) < fill);
  assign rem_part = (occ && (age_r == wm1)) ? val_r : '0;

  // median taps
  assign lo_part = (AGE_W'(IDX) == lo_idx) ? val_r : '0;
  assign hi_part = (AGE_W'(IDX) == hi_idx) ? val_r : '0;

  // cells above the leaving sample close the gap; equal values keep age order,
  // so the leaving sample is the last of its equals
  assign s     = ctl.full && (val_r > rem_val);
  assign u     = right_s ? right_val : val_r;
  assign u_age = right_s ? right_age : age_r;

  // new word goes in front of every cell at or above its value
  assign u_ok = (AGE_W'(IDX) < m_cnt);
  assign g    = !u_ok || (u >= amount);

  always_comb begin
    if (g) begin
      if (left_g) begin
        val_nxt = left_u;
        age_nxt = left_u_age + 1'b1;
      end else begin
        val_nxt = amount;
        age_nxt = '0;
      end
    end else begin
      val_nxt = u;
      age_nxt = u_age + 1'b1;
    end
  end

  // cell storage
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

### hw/rtl/sliding_median_threshold_alert_unit.sv
// channel | direction | handshake                  | payload
// in      | input     | in_valid / in_ready        | in_amount
// out     | output    | out_valid / out_ready      | window_full, alert, twice_median, alert_total
// cfg     | input     | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// one word per cycle: the sorted row of cells removes the oldest sample and
// inserts the new one in the cycle of acceptance, and the result appears in
// the output register on the next cycle.
// the result register frees itself in the cycle it is taken, so in_ready only
// drops while a result waits and out_ready is low.
// synchronous reset clears the window fill, the alert count, the window size
// (to 3) and the output valid; cell contents need no reset.
module sliding_median_threshold_alert_unit import smta_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_amount,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_window_full,
  output logic                   out_alert,
  output logic [SAMPLE_BITS:0]   out_twice_median,
  output logic [COUNT_W-1:0]     out_alert_total,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int AGE_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WCNT_W = $clog2(MAX_WINDOW + 1);

  logic [WSIZE_W-1:0]     wsize_r, wsize_nxt;
  logic [WCNT_W-1:0]      fill_r, fill_nxt;
  logic [COUNT_W-1:0]     cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   full_r, alert_r;
  logic [SAMPLE_BITS:0]   twice_r;

  logic                   cfg_wr;
  logic                   accept;
  logic [WCNT_W-1:0]      eff_w;
  logic [WCNT_W-1:0]      wm1;
  logic                   full;
  logic                   alert;
  logic [SAMPLE_BITS:0]   twice;
  logic [AGE_W-1:0]       m_cnt;
  logic [AGE_W-1:0]       lo_idx, hi_idx;
  logic [SAMPLE_BITS-1:0] rem_val, lo_val, hi_val;
  smta_ctl_t              ctl;

  logic [SAMPLE_BITS-1:0] cell_val  [MAX_WINDOW];
  logic [AGE_W-1:0]       cell_age  [MAX_WINDOW];
  logic                   cell_s    [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] cell_u    [MAX_WINDOW];
  logic [AGE_W-1:0]       cell_uage [MAX_WINDOW];
  logic                   cell_g    [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rem_part  [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] lo_part   [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] hi_part   [MAX_WINDOW];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_WINDOW_SIZE);
  assign prdata = (paddr == REG_WINDOW_SIZE) ? CFG_DATA_W'(wsize_r) : '0;
  assign wsize_nxt = cfg_wr ? pwdata[WSIZE_W-1:0] : wsize_r;

  // effective window: zero acts as one, large values saturate
  always_comb begin
    if (wsize_r == '0) begin
      eff_w = WCNT_W'(1);
    end else if (int'(wsize_r) > MAX_WINDOW) begin
      eff_w = WCNT_W'(MAX_WINDOW);
    end else begin
      eff_w = WCNT_W'(wsize_r);
    end
  end

  assign wm1    = eff_w - 1'b1;
  assign lo_idx = AGE_W'(wm1 >> 1);
  assign hi_idx = AGE_W'(eff_w >> 1);

  // handshake and window state
  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign full     = (fill_r >= eff_w);
  assign m_cnt    = full ? AGE_W'(wm1) : AGE_W'(fill_r);
  assign ctl.upd  = accept;
  assign ctl.full = full;

  // broadcast or-trees over the row
  always_comb begin
    rem_val = '0;
    lo_val  = '0;
    hi_val  = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      rem_val = rem_val | rem_part[i];
      lo_val  = lo_val | lo_part[i];
      hi_val  = hi_val | hi_part[i];
    end
  end

  // judgement of the new word
  assign twice = full ? ({1'b0, lo_val} + {1'b0, hi_val}) : '0;
  assign alert = full && ({1'b0, in_amount} >= twice);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && alert && (cnt_r != '1)) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_wr) begin
      fill_nxt = '0;
    end else if (accept) begin
      fill_nxt = full ? eff_w : fill_r + 1'b1;
    end
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // sorted row of cells
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] r_val;
    logic [AGE_W-1:0]       r_age;
    logic                   r_s;
    logic [SAMPLE_BITS-1:0] l_u;
    logic [AGE_W-1:0]       l_uage;
    logic                   l_g;

    if (i == MAX_WINDOW - 1) begin : g_right_end
      assign r_val = '0;
      assign r_age = '0;
      assign r_s   = 1'b0;
    end else begin : g_right
      assign r_val = cell_val[i+1];
      assign r_age = cell_age[i+1];
      assign r_s   = cell_s[i+1];
    end

    if (i == 0) begin : g_left_end
      assign l_u    = '0;
      assign l_uage = '0;
      assign l_g    = 1'b0;
    end else begin : g_left
      assign l_u    = cell_u[i-1];
      assign l_uage = cell_uage[i-1];
      assign l_g    = cell_g[i-1];
    end

    smta_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_W       (AGE_W),
      .WCNT_W      (WCNT_W),
      .IDX         (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .amount     (in_amount),
      .rem_val    (rem_val),
      .fill       (fill_r),
      .wm1        (AGE_W'(wm1)),
      .m_cnt      (m_cnt),
      .lo_idx     (lo_idx),
      .hi_idx     (hi_idx),
      .right_val  (r_val),
      .right_age  (r_age),
      .right_s    (r_s),
      .left_u     (l_u),
      .left_u_age (l_uage),
      .left_g     (l_g),
      .val        (cell_val[i]),
      .age        (cell_age[i]),
      .s          (cell_s[i]),
      .u          (cell_u[i]),
      .u_age      (cell_uage[i]),
      .g          (cell_g[i]),
      .rem_part   (rem_part[i]),
      .lo_part    (lo_part[i]),
      .hi_part    (hi_part[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r     <= WSIZE_RESET;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wsize_r     <= wsize_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      full_r  <= full;
      alert_r <= alert;
      twice_r <= twice;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_full  = full_r;
  assign out_alert        = alert_r;
  assign out_twice_median = twice_r;
  assign out_alert_total  = cnt_r;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= eff_w)
    else $error("fill level above window size");

  a_alert_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alert) |-> out_window_full)
    else $error("alert on a word that was not judged");

  a_twice_zero_filling: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_window_full) |-> (out_twice_median == '0))
    else $error("median reported while window filling");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r >= $past(cnt_r)))
    else $error("alert count went down");

endmodule

### tb/median_alert_checker.sv
`timescale 1ns / 1ps

module median_alert_checker import smta_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_amount,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_window_full,
  input  logic                   out_alert,
  input  logic [SAMPLE_BITS:0]   out_twice_median,
  input  logic [COUNT_W-1:0]     out_alert_total,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  input  logic [CFG_DATA_W-1:0]  prdata,
  input  logic                   pready,
  output int                     fail_count,
  output int                     pending_count,
  output int                     results_checked,
  output int                     alerts_seen
);

  typedef struct packed {
    logic                 full;
    logic                 alert;
    logic [SAMPLE_BITS:0] twice;
    logic [COUNT_W-1:0]   total;
  } verdict_t;

  // own copy of the window state
  logic [WSIZE_W-1:0]     win_reg;
  logic [SAMPLE_BITS-1:0] arrival [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] ordered [$];
  int                     fill;
  int                     oldest;
  logic [COUNT_W-1:0]     alert_count;
  verdict_t               awaited_verdicts [$];

  // window length actually in force
  function automatic int effective_window();
    if (win_reg == '0) return 1;
    if (int'(win_reg) > MAX_WINDOW) return MAX_WINDOW;
    return int'(win_reg);
  endfunction

  // judge one sample against the held window, then slide the window
  function automatic verdict_t judge_sample(input logic [SAMPLE_BITS-1:0] amount);
    int       w;
    int       mid;
    int       pos;
    verdict_t v;
    w = effective_window();
    v = '0;
    if (fill >= w) begin
      mid = w / 2;
      if (w % 2 == 1) begin
        v.twice = {ordered[mid], 1'b0};
      end else begin
        v.twice = {1'b0, ordered[mid-1]} + {1'b0, ordered[mid]};
      end
      v.full  = 1'b1;
      v.alert = ({1'b0, amount} >= v.twice);
      if (v.alert && alert_count != '1) alert_count++;
      // oldest sample leaves: drop one cell of equal value
      pos = 0;
      while (pos < ordered.size() && ordered[pos] != arrival[oldest]) pos++;
      if (pos < ordered.size()) ordered.delete(pos);
      fill = w;
    end else begin
      fill++;
    end
    // new sample enters in order
    pos = 0;
    while (pos < ordered.size() && ordered[pos] <= amount) pos++;
    ordered.insert(pos, amount);
    arrival[oldest] = amount;
    oldest = (oldest + 1 >= w) ? 0 : oldest + 1;
    v.total = alert_count;
    return v;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: MISMATCH %s", $realtime, what);
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      win_reg     = WSIZE_RESET;
      fill        = 0;
      oldest      = 0;
      alert_count = '0;
      ordered.delete();
      awaited_verdicts.delete();
    end else begin
      // register access
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == REG_WINDOW_SIZE) begin
            win_reg = pwdata[WSIZE_W-1:0];
            fill    = 0;
            oldest  = 0;
            ordered.delete();
          end
        end else if (paddr == REG_WINDOW_SIZE && prdata !== CFG_DATA_W'(win_reg)) begin
          note_failure($sformatf("window_size read exp %0d got %0d", win_reg, prdata));
        end
      end
      // result word against the oldest expectation
      if (out_valid && out_ready) begin
        got = '{out_window_full, out_alert, out_twice_median, out_alert_total};
        if (awaited_verdicts.size() == 0) begin
          note_failure($sformatf("result word with nothing expected: full=%0b alert=%0b %s",
                                 got.full, got.alert,
                                 $sformatf("twice=%0d total=%0d", got.twice, got.total)));
        end else begin
          want = awaited_verdicts.pop_front();
          if (got !== want) begin
            note_failure($sformatf({"exp full=%0b alert=%0b twice=%0d total=%0d, ",
                                    "got full=%0b alert=%0b twice=%0d total=%0d"},
                                   want.full, want.alert, want.twice, want.total,
                                   got.full, got.alert, got.twice, got.total));
          end
        end
        results_checked++;
        if (out_alert === 1'b1) alerts_seen++;
      end
      // sample word accepted
      if (in_valid && in_ready) begin
        awaited_verdicts.insert(awaited_verdicts.size(), judge_sample(in_amount));
      end
    end
    pending_count = awaited_verdicts.size();
  end

endmodule

### tb/sliding_median_threshold_alert_unit_test.sv
`timescale 1ns / 1ps

module sliding_median_threshold_alert_unit_test;
  import smta_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int NUM_PHASES  = 11;

  // window settings for the random part, extremes included
  localparam logic [WSIZE_W-1:0] PHASE_WIN [NUM_PHASES] =
    '{7'd2, 7'd64, 7'd0, 7'd7, 7'd127, 7'd1, 7'd4, 7'd33, 7'd100, 7'd3, 7'd5};
  localparam int PHASE_LEN [NUM_PHASES] = '{40, 110, 40, 35, 80, 30, 40, 55, 70, 40, 40};

  // default window of three: threshold equality, extremes, equal samples
  localparam logic [SAMPLE_BITS-1:0] RUN_W3 [12] = '{16'h0000, 16'hFFFF, 16'h0001,
    16'h0002, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0007, 16'h0007, 16'h0007, 16'h000E,
    16'h000D};
  // size zero behaves as one: largest possible threshold
  localparam logic [SAMPLE_BITS-1:0] RUN_W1 [4] = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001};
  // even window: sum of the two middle cells
  localparam logic [SAMPLE_BITS-1:0] RUN_W2 [4] = '{16'h0003, 16'h0005, 16'h0008, 16'h0008};

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_amount = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_window_full;
  logic                   out_alert;
  logic [SAMPLE_BITS:0]   out_twice_median;
  logic [COUNT_W-1:0]     out_alert_total;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr     = '0;
  logic [CFG_DATA_W-1:0]  pwdata    = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  int fail_count;
  int pending_count;
  int results_checked;
  int alerts_seen;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int samples_sent = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sliding_median_threshold_alert_unit #(
    .MAX_WINDOW (64),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (.*);

  median_alert_checker #(
    .MAX_WINDOW (64),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) checker_i (.*);

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0; stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct = 67; stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0; stall_pct = 67;
      end
      default: begin
        gap_pct = 23; stall_pct = 23;
      end
    endcase
  endtask

  // one sample word, with random gaps before it
  task automatic send_word(input logic [SAMPLE_BITS-1:0] v);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_amount <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    samples_sent++;
  endtask

  // stop sending and let every result drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic reg_write(input logic [WSIZE_W-1:0] wsize);
    logic [CFG_DATA_W-1:0] noise;
    noise   = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_WINDOW_SIZE;
    pwdata  <= {noise[CFG_DATA_W-1:WSIZE_W], wsize};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_read();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_WINDOW_SIZE;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // mix of uniform values, low levels, spikes, repeats and extremes
  function automatic logic [SAMPLE_BITS-1:0] draw_sample(input logic [SAMPLE_BITS-1:0] last);
    int r;
    r = $urandom_range(99);
    if (r < 40) return SAMPLE_BITS'($urandom_range(65535));
    if (r < 65) return SAMPLE_BITS'($urandom_range(200));
    if (r < 75) return SAMPLE_BITS'($urandom_range(65535, 30000));
    if (r < 85) return last;
    if (r < 92) return '0;
    return '1;
  endfunction

  // receiver back-pressure
  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [SAMPLE_BITS-1:0] last;
    last = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, no idling
    set_idle(IDLE_NONE);
    reg_read();
    foreach (RUN_W3[i]) send_word(RUN_W3[i]);
    settle();
    reg_write(7'd0);
    reg_read();
    foreach (RUN_W1[i]) send_word(RUN_W1[i]);
    settle();
    reg_write(7'd2);
    foreach (RUN_W2[i]) send_word(RUN_W2[i]);

    // random part, one window setting and idle pattern per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      reg_write(PHASE_WIN[p]);
      reg_read();
      set_idle(idle_mode_e'(p % 4));
      for (int n = 0; n < PHASE_LEN[p]; n++) begin
        last = draw_sample(last);
        send_word(last);
      end
    end
    settle();
    repeat (3) @(negedge clk);

    $display("%0d samples sent over %0d window settings from 0 to 127, four idle patterns",
             samples_sent, NUM_PHASES + 3);
    $display("%0d results checked, %0d alerts raised", results_checked, alerts_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
